>>> sv/rgb_led_pulse_width_encoder_defines.svh
// assertion macros for the rgb led pulse width encoder
// needs clk and rst_n in the scope of every use
`ifndef RGB_LED_PULSE_WIDTH_ENCODER_DEFINES_SVH
`define RGB_LED_PULSE_WIDTH_ENCODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define RLPWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RLPWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rlpwe_pkg.sv
// constants, register indexes and tangent table for the rgb led encoder
// no dependencies
package rlpwe_pkg;

  localparam int BITS_PER_LED = 24;
  localparam int CNT_W        = $clog2(BITS_PER_LED + 1);
  localparam int BYTE_W       = 8;
  localparam int BRIGHT_W     = 6;
  localparam int TAN_W        = 17;
  localparam int MAX_BRIGHT   = 45;

  localparam logic              RST_DIM_EN    = 1'b1;
  localparam logic [BRIGHT_W-1:0] RST_BRIGHT  = BRIGHT_W'(MAX_BRIGHT);
  localparam logic [BYTE_W-1:0] RST_DUTY_ONE  = 8'd60;
  localparam logic [BYTE_W-1:0] RST_DUTY_ZERO = 8'd30;

  typedef enum logic [1:0] {
    REG_DIM_EN    = 2'd0,
    REG_BRIGHT    = 2'd1,
    REG_DUTY_ONE  = 2'd2,
    REG_DUTY_ZERO = 2'd3
  } reg_idx_t;

  // round(tan(k deg) * 2^16), unsigned q1.16
  localparam logic [TAN_W-1:0] TAN_Q16 [0:MAX_BRIGHT] = '{
    17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,  17'd6888,
    17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739, 17'd13930, 17'd15130,
    17'd16340, 17'd17560, 17'd18792, 17'd20036, 17'd21294, 17'd22566, 17'd23853,
    17'd25157, 17'd26478, 17'd27818, 17'd29179, 17'd30560, 17'd31964, 17'd33392,
    17'd34846, 17'd36327, 17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205,
    17'd45889, 17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
    17'd59009, 17'd61113, 17'd63287, 17'd65536
  };

endpackage

>>> sv/rgb_led_pulse_width_encoder.sv
// rgb led pulse width encoder: colour in, one timer compare value per bit out
// depends on rlpwe_pkg and rgb_led_pulse_width_encoder_defines.svh
//
// usage
//   in_*   : one item per led (red, green, blue, final_led), valid/ready
//   out_*  : one item per bit slot (compare_value, run_end), valid/ready
//   cfg_*  : plain write port, index 0 dimming enable, 1 brightness (0..45,
//            bits 5:0 used, 46..63 saturate), 2 duty for a one bit, 3 duty for a zero
//   each led gives 24 slots, blue:red:green msb first; a led flagged
//   final_led adds one slot with compare value 0. run_end marks the last
//   slot of every led
// path: the first slot of an item passes the input register, the shifter, then the output register
// throughput: the single bit shifter sends one slot per cycle while the receiver
//   does not stall; the input register takes the next led while the current
//   one is still being shifted out
// reset (synchronous, rst_n low): all stages empty, registers back to
//   dimming on, brightness 45, duties 60 and 30
// receiver stall: the output register holds its slot, the shifter and then
//   the input register stop, and in_ready drops once the input stage is full
`include "rgb_led_pulse_width_encoder_defines.svh"

module rgb_led_pulse_width_encoder
  import rlpwe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // config port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  // led colour items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_red,
  input  logic [BYTE_W-1:0] in_green,
  input  logic [BYTE_W-1:0] in_blue,
  input  logic              in_final_led,
  // bit slot items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_compare_value,
  output logic              out_run_end
);

  // configuration registers
  logic                dim_en_r;
  logic [BRIGHT_W-1:0] bright_r;
  logic [BYTE_W-1:0]   duty_one_r;
  logic [BYTE_W-1:0]   duty_zero_r;
  logic [BRIGHT_W-1:0] bright_nxt;

  // input stage
  logic              valid_a_r;
  logic [BYTE_W-1:0] red_a_r, green_a_r, blue_a_r;
  logic              final_a_r;

  // shifter stage
  logic                    busy_b_r;
  logic [BITS_PER_LED-1:0] word_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    final_b_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_cmp_r;
  logic              out_end_r;

  logic                    out_adv, step, last_slot, b_done, load_b;
  logic [BITS_PER_LED-1:0] word_nxt;
  logic [BYTE_W-1:0]       cmp_nxt;
  logic                    end_nxt;

  // brightness writes of 46..63 saturate; only bits 5:0 of cfg_data are used
  assign bright_nxt = (cfg_data[BRIGHT_W-1:0] > BRIGHT_W'(MAX_BRIGHT)) ?
                      BRIGHT_W'(MAX_BRIGHT) : cfg_data[BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_en_r    <= RST_DIM_EN;
      bright_r    <= RST_BRIGHT;
      duty_one_r  <= RST_DUTY_ONE;
      duty_zero_r <= RST_DUTY_ZERO;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIM_EN:    dim_en_r    <= cfg_data[0];
        REG_BRIGHT:    bright_r    <= bright_nxt;
        REG_DUTY_ONE:  duty_one_r  <= cfg_data;
        REG_DUTY_ZERO: duty_zero_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // colour shading: clear bit 0, optionally scale by tan and floor, clear bit 0
  function automatic logic [BYTE_W-1:0] shade(input logic [BYTE_W-1:0] raw,
                                              input logic                en,
                                              input logic [TAN_W-1:0]    tanv);
    logic [BYTE_W-1:0]       v;
    logic [BYTE_W+TAN_W-1:0] prod;
    v    = raw & 8'hFE;
    prod = (BYTE_W+TAN_W)'(v) * (BYTE_W+TAN_W)'(tanv);
    if (en) begin
      v = prod[BYTE_W+15:16] & 8'hFE;
    end
    return v;
  endfunction

  logic [TAN_W-1:0] tan_sel;
  assign tan_sel  = TAN_Q16[bright_r];
  assign word_nxt = {shade(blue_a_r,  dim_en_r, tan_sel),
                     shade(red_a_r,   dim_en_r, tan_sel),
                     shade(green_a_r, dim_en_r, tan_sel)};

  // slot sequencing: slots 0..23 are colour bits, slot 24 the zero slot
  assign out_adv   = !out_valid_r || out_ready;
  assign step      = busy_b_r && out_adv;
  assign last_slot = (cnt_r == CNT_W'(BITS_PER_LED)) ||
                     ((cnt_r == CNT_W'(BITS_PER_LED - 1)) && !final_b_r);
  assign b_done    = step && last_slot;
  assign load_b    = valid_a_r && (!busy_b_r || b_done);
  assign in_ready  = !valid_a_r || load_b;

  assign cmp_nxt = (cnt_r == CNT_W'(BITS_PER_LED)) ? '0 :
                   (word_r[BITS_PER_LED-1] ? duty_one_r : duty_zero_r);
  assign end_nxt = last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_a_r <= 1'b1;
    end else if (load_b) begin
      valid_a_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_a_r   <= in_red;
      green_a_r <= in_green;
      blue_a_r  <= in_blue;
      final_a_r <= in_final_led;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_b_r <= 1'b0;
      cnt_r    <= '0;
    end else if (load_b) begin
      busy_b_r <= 1'b1;
      cnt_r    <= '0;
    end else if (b_done) begin
      busy_b_r <= 1'b0;
    end else if (step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      word_r    <= word_nxt;
      final_b_r <= final_a_r;
    end else if (step) begin
      word_r <= {word_r[BITS_PER_LED-2:0], 1'b0};
    end
  end

  // output register, decouples the shifter from the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= busy_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_cmp_r <= cmp_nxt;
      out_end_r <= end_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = out_cmp_r;
  assign out_run_end       = out_end_r;

  `RLPWE_ASSERT_NOW(a_cnt_range, busy_b_r, cnt_r <= CNT_W'(BITS_PER_LED),
                    "slot counter beyond the zero slot")
  `RLPWE_ASSERT_NEXT(a_done_marks_end, b_done, out_valid_r && out_end_r,
                     "last slot of an item sent without run_end")
  `RLPWE_ASSERT_NEXT(a_load_restarts, load_b, busy_b_r && (cnt_r == '0),
                     "shifter did not restart on a new item")
  `RLPWE_ASSERT_NEXT(a_hold_input, valid_a_r && !load_b,
                     valid_a_r && $stable(red_a_r) && $stable(final_a_r),
                     "waiting input item was overwritten")

endmodule

>>> tb/rgb_led_pulse_width_encoder_tb.sv
// self-checking testbench for rgb_led_pulse_width_encoder: led colours in, bit slots out
// drives random and directed led items under varied idling and register settings
// depends on rlpwe_pkg for register indexes, widths and the tangent table
module rgb_led_pulse_width_encoder_tb;
  import rlpwe_pkg::*;

  // generous watchdog, well above the slowest run with heavy receiver stalls
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int LEDS_PER_PHASE = 63;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              final_led;
  } led_t;

  typedef struct packed {
    logic [BYTE_W-1:0] compare_value;
    logic              run_end;
  } slot_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_red = '0;
  logic [BYTE_W-1:0] in_green = '0;
  logic [BYTE_W-1:0] in_blue = '0;
  logic              in_final_led = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_compare_value;
  logic              out_run_end;

  // leds waiting to be sent and bit slots waiting to come back
  led_t  pending_leds[$];
  slot_t expected_slots[$];

  // own copy of the register file, only changed while the block is idle
  logic              dim_on;
  logic [BRIGHT_W-1:0] bright_deg;
  logic [BYTE_W-1:0] duty_for_one;
  logic [BYTE_W-1:0] duty_for_zero;

  // idling percentages for the current phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int failures = 0;
  int cycle_count = 0;

  rgb_led_pulse_width_encoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_final_led      (in_final_led),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_compare_value (out_compare_value),
    .out_run_end       (out_run_end)
  );

  always #1 clk = ~clk;

  // colour byte: bit 0 cleared; if dim_on, q1.16 tan scaling with floor, bit 0 cleared again
  function automatic logic [BYTE_W-1:0] dim_byte(input logic [BYTE_W-1:0] colour);
    logic [BYTE_W-1:0] v;
    logic [24:0]       prod;
    v = colour & 8'hFE;
    if (dim_on) begin
      prod = v * TAN_Q16[bright_deg];
      v = prod[23:16] & 8'hFE;
    end
    return v;
  endfunction

  // expand one led into its 24 bit slots, blue:red:green msb first, plus a zero slot if final
  task automatic queue_led_slots(input led_t led);
    logic [BITS_PER_LED-1:0] word;
    slot_t s;
    word = {dim_byte(led.blue), dim_byte(led.red), dim_byte(led.green)};
    for (int i = BITS_PER_LED - 1; i >= 0; i--) begin
      s.compare_value = word[i] ? duty_for_one : duty_for_zero;
      s.run_end = (i == 0) && !led.final_led;
      expected_slots.push_back(s);
    end
    if (led.final_led) begin
      s.compare_value = '0;
      s.run_end = 1'b1;
      expected_slots.push_back(s);
    end
  endtask

  // sender: holds valid and payload until accepted, then may idle before the next item
  always @(posedge clk) begin
    led_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // prediction uses the payload as it stands at the accepting edge
      if (in_valid && in_ready) begin
        queue_led_slots({in_red, in_green, in_blue, in_final_led});
      end
      if (!in_valid || in_ready) begin
        if (pending_leds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_leds.pop_front();
          in_valid     <= 1'b1;
          in_red       <= nxt.red;
          in_green     <= nxt.green;
          in_blue      <= nxt.blue;
          in_final_led <= nxt.final_led;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls at random according to the phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // checker: every accepted slot against the oldest expectation
  always @(posedge clk) begin
    slot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_slots.size() == 0) begin
        $error("slot with nothing expected: compare_value %0d run_end %0d",
               out_compare_value, out_run_end);
        failures++;
      end else begin
        want = expected_slots.pop_front();
        if (out_compare_value !== want.compare_value) begin
          $error("compare_value expected %0d actual %0d", want.compare_value,
                 out_compare_value);
          failures++;
        end
        if (out_run_end !== want.run_end) begin
          $error("run_end expected %0d actual %0d", want.run_end, out_run_end);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DIM_EN:    dim_on = data[0];
      REG_BRIGHT:    bright_deg = (data[5:0] > MAX_BRIGHT) ? BRIGHT_W'(MAX_BRIGHT) : data[5:0];
      REG_DUTY_ONE:  duty_for_one = data;
      REG_DUTY_ZERO: duty_for_zero = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic fin);
    pending_leds.push_back({r, g, b, fin});
  endtask

  // sampled at the falling edge so that queue pops and valid updates have settled;
  // the extra cycles give margin before the next register write
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_leds.size() != 0 || in_valid || expected_slots.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // colour byte biased towards the extremes
  function automatic logic [7:0] pick_colour();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_duty();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_random_leds(input int n);
    for (int i = 0; i < n; i++) begin
      add_led(pick_colour(), pick_colour(), pick_colour(), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    logic [7:0] bright_pick;
    // registers come out of reset as dimming on, brightness 45, duties 60 and 30
    dim_on        = RST_DIM_EN;
    bright_deg    = RST_BRIGHT;
    duty_for_one  = RST_DUTY_ONE;
    duty_for_zero = RST_DUTY_ZERO;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full brightness, extremes and bit 0 clearing
    add_led(8'h00, 8'h00, 8'h00, 1'b0);
    add_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_led(8'h01, 8'h01, 8'h01, 1'b0);
    add_led(8'hAA, 8'h55, 8'h0F, 1'b1);
    wait_idle();

    // dimming off, bytes pass with only bit 0 cleared
    write_reg(REG_DIM_EN, 8'd0);
    write_reg(REG_DUTY_ONE, 8'd255);
    write_reg(REG_DUTY_ZERO, 8'd0);
    add_led(8'hFF, 8'h00, 8'hFF, 1'b0);
    add_led(8'h01, 8'hFE, 8'h81, 1'b1);
    add_led(8'h55, 8'hAA, 8'hF0, 1'b1);
    wait_idle();

    // zero angle blanks every colour
    write_reg(REG_DIM_EN, 8'd1);
    write_reg(REG_BRIGHT, 8'd0);
    add_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_idle();

    // brightness above range saturates to 45
    write_reg(REG_BRIGHT, 8'd63);
    add_led(8'hFF, 8'h80, 8'h7F, 1'b1);
    wait_idle();
    write_reg(REG_BRIGHT, 8'd46);
    add_led(8'hC3, 8'h3C, 8'h99, 1'b0);
    wait_idle();

    // smallest non-zero angle and one just below the top
    write_reg(REG_BRIGHT, 8'd1);
    add_led(8'hFF, 8'hFE, 8'h80, 1'b1);
    wait_idle();
    write_reg(REG_BRIGHT, 8'd44);
    add_led(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_led(8'h12, 8'h34, 8'h56, 1'b1);
    wait_idle();

    // swapped duty extremes
    write_reg(REG_DUTY_ONE, 8'd0);
    write_reg(REG_DUTY_ZERO, 8'd255);
    add_led(8'hA5, 8'h5A, 8'hFF, 1'b1);
    wait_idle();

    // random phases, each with fresh settings and its own idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      case ($urandom_range(3))
        0:       bright_pick = 8'd0;
        1:       bright_pick = 8'd45;
        2:       bright_pick = 8'($urandom_range(46, 63));
        default: bright_pick = 8'($urandom_range(45));
      endcase
      write_reg(REG_DIM_EN, 8'($urandom_range(3) != 0));
      write_reg(REG_BRIGHT, bright_pick);
      write_reg(REG_DUTY_ONE, pick_duty());
      write_reg(REG_DUTY_ZERO, pick_duty());
      if (p == 2) begin
        // sender holds off mid-phase until every slot has come back
        add_random_leds(LEDS_PER_PHASE / 2);
        wait_idle();
        add_random_leds(LEDS_PER_PHASE - LEDS_PER_PHASE / 2);
      end else begin
        add_random_leds(LEDS_PER_PHASE);
      end
      wait_idle();
    end

    // let any stray slot show itself
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_slots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rlpwe_pkg.sv
sv/rgb_led_pulse_width_encoder.sv
tb/rgb_led_pulse_width_encoder_tb.sv
